>>> hdl/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 8;

    typedef enum logic {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEQ,
        S_SCAN,
        S_PLACE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [PRIO_W-1:0]         prio;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic                      valid;
        status_t                   status;
        logic signed [VALUE_W-1:0] value;
    } result_t;

endpackage
`default_nettype wire

>>> hdl/spq_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel: one enqueue or dequeue transaction per handshake.
// ----------------------------------------------------------------------------
interface spq_req_if;

    logic                              valid;
    logic                              ready;
    spq_pkg::kind_t                    kind;
    logic signed [spq_pkg::VALUE_W-1:0] item_value;
    logic [spq_pkg::PRIO_W-1:0]        item_priority;

    modport source (output valid, output kind, output item_value, output item_priority,
                    input ready);
    modport sink (input valid, input kind, input item_value, input item_priority,
                  output ready);

endinterface
`default_nettype wire

>>> hdl/spq_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_rsp_if
// Response channel: one status and value per request transaction.
// ----------------------------------------------------------------------------
interface spq_rsp_if;

    logic                              valid;
    logic                              ready;
    spq_pkg::status_t                  status;
    logic signed [spq_pkg::VALUE_W-1:0] out_value;

    modport source (output valid, output status, output out_value, input ready);
    modport sink (input valid, input status, input out_value, output ready);

endinterface
`default_nettype wire

>>> hdl/spq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> hdl/spq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer of the sorted queue: keeps the circular window over the entry
// RAM and performs the backward insertion scan and the head removal.
// ----------------------------------------------------------------------------
module spq_ctrl #(
    parameter int CAPACITY = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    spq_req_if.sink                          req,
    output logic                             ram_we,
    output logic [$clog2(CAPACITY)-1:0]      ram_waddr,
    output spq_pkg::entry_t                  ram_wdata,
    output logic [$clog2(CAPACITY)-1:0]      ram_raddr,
    input  wire spq_pkg::entry_t             ram_rdata,
    output spq_pkg::result_t                 res,
    input  wire logic                        res_taken
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(CAPACITY - 1) : p - 1'b1;
    endfunction

    spq_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [AW-1:0]   tail_reg, tail_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]   left_reg, left_next;
    spq_pkg::entry_t new_entry_reg, new_entry_next;
    spq_pkg::status_t res_status_reg, res_status_next;
    logic signed [spq_pkg::VALUE_W-1:0] res_value_reg, res_value_next;

    logic accept;
    logic is_deq;
    logic q_full;
    logic q_empty;
    logic do_shift;
    logic last_one;

    assign accept   = req.valid && req.ready;
    assign is_deq   = (req.kind == spq_pkg::KIND_DEQ);
    assign q_full   = (count_reg == CW'(CAPACITY));
    assign q_empty  = (count_reg == '0);
    assign do_shift = (ram_rdata.prio < new_entry_reg.prio);
    assign last_one = (left_reg == CW'(1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (is_deq)
                    begin
                        state_next = q_empty ? spq_pkg::S_FINISH : spq_pkg::S_DEQ;
                    end
                    else if (q_full || q_empty)
                    begin
                        state_next = spq_pkg::S_FINISH;
                    end
                    else
                    begin
                        state_next = spq_pkg::S_SCAN;
                    end
                end
            end
            spq_pkg::S_DEQ:
            begin
                state_next = spq_pkg::S_FINISH;
            end
            spq_pkg::S_SCAN:
            begin
                if (!do_shift)
                begin
                    state_next = spq_pkg::S_FINISH;
                end
                else if (last_one)
                begin
                    state_next = spq_pkg::S_PLACE;
                end
            end
            spq_pkg::S_PLACE:
            begin
                state_next = spq_pkg::S_FINISH;
            end
            spq_pkg::S_FINISH:
            begin
                if (res_taken)
                begin
                    state_next = spq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = wr_ptr_reg;
        ram_wdata  = new_entry_reg;
        ram_raddr  = rd_ptr_reg;
        res.valid  = 1'b0;
        res.status = res_status_reg;
        res.value  = res_value_reg;
        unique case (state_reg)
            spq_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                if (is_deq)
                begin
                    ram_raddr = head_reg;
                end
                else
                begin
                    ram_raddr = ptr_dec(tail_reg);
                    ram_waddr = tail_reg;
                    ram_wdata = '{prio: req.item_priority, value: req.item_value};
                    ram_we    = accept && q_empty;
                end
            end
            spq_pkg::S_SCAN:
            begin
                ram_we    = 1'b1;
                ram_waddr = wr_ptr_reg;
                ram_wdata = do_shift ? ram_rdata : new_entry_reg;
                ram_raddr = ptr_dec(rd_ptr_reg);
            end
            spq_pkg::S_PLACE:
            begin
                ram_we = 1'b1;
            end
            spq_pkg::S_FINISH:
            begin
                res.valid = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        left_next       = left_reg;
        new_entry_next  = new_entry_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    new_entry_next  = '{prio: req.item_priority, value: req.item_value};
                    res_status_next = spq_pkg::ST_OK;
                    res_value_next  = '0;
                    if (is_deq)
                    begin
                        if (q_empty)
                        begin
                            res_status_next = spq_pkg::ST_EMPTY;
                        end
                    end
                    else if (q_full)
                    begin
                        res_status_next = spq_pkg::ST_FULL;
                    end
                    else
                    begin
                        rd_ptr_next = ptr_dec(tail_reg);
                        wr_ptr_next = tail_reg;
                        left_next   = count_reg;
                        tail_next   = ptr_inc(tail_reg);
                        count_next  = count_reg + 1'b1;
                    end
                end
            end
            spq_pkg::S_DEQ:
            begin
                res_value_next = ram_rdata.value;
                head_next      = ptr_inc(head_reg);
                count_next     = count_reg - 1'b1;
            end
            spq_pkg::S_SCAN:
            begin
                if (do_shift)
                begin
                    wr_ptr_next = rd_ptr_reg;
                    rd_ptr_next = ptr_dec(rd_ptr_reg);
                    left_next   = left_reg - 1'b1;
                end
            end
            default:
            begin
                left_next = left_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg     <= rd_ptr_next;
        wr_ptr_reg     <= wr_ptr_next;
        left_reg       <= left_next;
        new_entry_reg  <= new_entry_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
    end

endmodule
`default_nettype wire

>>> hdl/sorted_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a circular entry RAM.
// ----------------------------------------------------------------------------
// Each request transaction gives exactly one response transaction. Entries
// sit in one RAM in descending priority, oldest first among equal
// priorities, inside a circular window, so a dequeue only reads the head
// in S_DEQ before S_FINISH. An enqueue walks back from the tail in S_SCAN,
// moving one lower-priority entry a cycle through the single RAM write
// port, and writes the new entry in S_SCAN or S_PLACE; an enqueue into an
// empty queue, a full enqueue and an empty dequeue go straight to S_FINISH.
// The response sits in an output register, and a new request waits until
// the previous response has entered it, once the register is empty or read.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    localparam int AW = $clog2(CAPACITY);

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    spq_pkg::entry_t  ram_wdata;
    logic [AW-1:0]    ram_raddr;
    spq_pkg::entry_t  ram_rdata;
    spq_pkg::result_t res;
    logic             res_taken;

    logic                               out_valid_reg;
    spq_pkg::status_t                   out_status_reg;
    logic signed [spq_pkg::VALUE_W-1:0] out_value_reg;

    spq_ram #(
        .WIDTH ($bits(spq_pkg::entry_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    spq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res       (res),
        .res_taken (res_taken)
    );

    assign res_taken = res.valid && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_taken)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_taken)
        begin
            out_status_reg <= res.status;
            out_value_reg  <= res.value;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.out_value = out_value_reg;

endmodule
`default_nettype wire
